// File: sv/c2d_pkg.sv
// Shared constants, codes and types for the direct 2D convolution engine.
package c2d_pkg;

	// Store sizes.
	localparam int IMAGE_WORDS      = 4096;
	localparam int WEIGHT_WORDS     = 4096;
	localparam int MAX_OUT_CHANNELS = 64;

	localparam int IMAGE_AW  = $clog2(IMAGE_WORDS);
	localparam int WEIGHT_AW = $clog2(WEIGHT_WORDS);
	localparam int BIAS_AW   = $clog2(MAX_OUT_CHANNELS);

	// Port field widths.
	localparam int FUNC_W      = 2;
	localparam int LOAD_ADDR_W = 12;
	localparam int VALUE_W     = 32;
	localparam int IDX_W       = 6;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;

	// Datapath widths.
	localparam int SAMPLE_W = 16;
	localparam int MUL_W    = 18;
	localparam int ACC_W    = 48;

	localparam logic signed [VALUE_W-1:0] RESULT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] RESULT_MIN = 32'sh8000_0000;

	// Request function codes.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD_WEIGHT = 2'd0,
		FUNC_LOAD_BIAS   = 2'd1,
		FUNC_LOAD_SAMPLE = 2'd2,
		FUNC_COMPUTE     = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_GRID    = 2'd1,
		STATUS_OVERRUN = 2'd2
	} status_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_CHANNELS  = 3'd0,
		CFG_IN_HEIGHT    = 3'd1,
		CFG_IN_WIDTH     = 3'd2,
		CFG_OUT_CHANNELS = 3'd3,
		CFG_K_HEIGHT     = 3'd4,
		CFG_K_WIDTH      = 3'd5,
		CFG_STEP         = 3'd6,
		CFG_PAD          = 3'd7
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SETUP  = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_TAP    = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// Setup steps: each but SU_LAST issues one product on the shared multiplier.
	typedef enum logic [3:0] {
		SU_RS    = 4'd0,
		SU_CS    = 4'd1,
		SU_IMGC  = 4'd2,
		SU_HW    = 4'd3,
		SU_KK    = 4'd4,
		SU_IH0W  = 4'd5,
		SU_CKK   = 4'd6,
		SU_CHAN0 = 4'd7,
		SU_KA0   = 4'd8,
		SU_LAST  = 4'd9
	} setup_step_t;

endpackage

// File: sv/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/conv2d_direct_mac.sv
// Direct NCHW 2D convolution engine: one output point per compute request.
// Load requests (weight, bias, sample) write straight into the stores.
// A compute request runs through the setup steps on the shared 18x18 multiplier,
// one grid check, one filter tap per cycle, a drain of the multiply pipeline
// and the load of the output register.
// Reset restores the default geometry and marks every bias unwritten; samples and weights are kept.
module conv2d_direct_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [c2d_pkg::FUNC_W-1:0]          func,
	input  logic [c2d_pkg::LOAD_ADDR_W-1:0]     load_address,
	input  logic signed [c2d_pkg::VALUE_W-1:0]  load_value,
	input  logic [c2d_pkg::IDX_W-1:0]           image_index,
	input  logic [c2d_pkg::IDX_W-1:0]           out_channel,
	input  logic [c2d_pkg::IDX_W-1:0]           out_row,
	input  logic [c2d_pkg::IDX_W-1:0]           out_col,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [c2d_pkg::VALUE_W-1:0]  result_value,
	output logic [c2d_pkg::STATUS_W-1:0]        status
);
	import c2d_pkg::*;

	// Configuration registers.
	logic [6:0] in_ch_q, in_h_q, in_w_q, out_ch_q;
	logic [3:0] k_h_q, k_w_q, step_q_cfg;
	logic [2:0] pad_q;

	// Control.
	state_t      state_q;
	setup_step_t step_q;
	logic        in_accept;
	logic        tap_s1, mac_s2;
	logic        out_valid_q;
	logic [MAX_OUT_CHANNELS-1:0] bias_valid_q;

	// Latched request fields.
	logic [IDX_W-1:0] img_q, oc_q, orow_q, ocol_q;

	// Setup products.
	logic [9:0]         rs_q, cs_q;
	logic [12:0]        imgc_q;
	logic [13:0]        hw_q;
	logic [7:0]         kk_q;
	logic signed [17:0] ih0w_q;
	logic [14:0]        ckk_q;
	logic [26:0]        chan0_q;
	logic [20:0]        ka0_q;

	// Tap walk.
	logic [6:0]         ic_q;
	logic [3:0]         r_q, c_q;
	logic signed [11:0] ih_q, iw_q;
	logic [27:0]        base_ic_q;
	logic [27:0]        base_ic_nxt;
	logic signed [29:0] row_q;
	logic [20:0]        ka_q;
	logic signed [29:0] xa;

	// Shared multiplier and accumulator.
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      grid_bad_q, ovf_q;

	// Result register.
	logic signed [VALUE_W-1:0] result_q;
	status_t                   status_q;

	// Store ports.
	logic                 img_wr_en, wgt_wr_en, bias_wr_en, tap_rd_en;
	logic [BIAS_AW-1:0]   bias_wr_addr;
	logic [SAMPLE_W-1:0]  img_rd, wgt_rd;
	logic [VALUE_W-1:0]   bias_rd;

	// Derived values.
	logic [3:0]         stride;
	logic signed [11:0] ih0, iw0;
	logic [10:0]        span_h, span_w, need_h, need_w;
	logic               in_grid, oc_over, no_taps;
	logic               ih_ok, iw_ok, tap_in, tap_over;
	logic               last_c, last_r, last_ic, last_tap;
	logic               acc_fits;
	status_t            fin_status;
	logic signed [VALUE_W-1:0] fin_value;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// A zero stride behaves as one.
	assign stride = (step_q_cfg == 4'd0) ? 4'd1 : step_q_cfg;

	// First input row and column under the window, padding removed.
	assign ih0 = $signed({2'b00, rs_q}) - $signed({9'b0, pad_q});
	assign iw0 = $signed({2'b00, cs_q}) - $signed({9'b0, pad_q});

	// A point is on the grid when its window fits inside the padded plane and its output channel is configured.
	assign span_h  = 11'(in_h_q) + 11'({pad_q, 1'b0});
	assign span_w  = 11'(in_w_q) + 11'({pad_q, 1'b0});
	assign need_h  = 11'(rs_q) + 11'(k_h_q);
	assign need_w  = 11'(cs_q) + 11'(k_w_q);
	assign in_grid = (need_h <= span_h) && (need_w <= span_w) && ({1'b0, oc_q} < out_ch_q);
	assign oc_over = (int'(oc_q) >= MAX_OUT_CHANNELS);
	assign no_taps = (in_ch_q == 7'd0) || (k_h_q == 4'd0) || (k_w_q == 4'd0);

	// Current tap: padding test, flat addresses and store bounds.
	assign ih_ok    = !ih_q[11] && (ih_q[10:0] < 11'(in_h_q));
	assign iw_ok    = !iw_q[11] && (iw_q[10:0] < 11'(in_w_q));
	assign tap_in   = ih_ok && iw_ok;
	assign xa       = row_q + 30'(iw_q);
	assign tap_over = tap_in && (($unsigned(xa) >= 30'(IMAGE_WORDS))
		|| (ka_q >= 21'(WEIGHT_WORDS)));
	assign tap_rd_en = (state_q == ST_TAP) && tap_in && !tap_over;

	assign last_c      = (c_q == k_w_q - 4'd1);
	assign last_r      = (r_q == k_h_q - 4'd1);
	assign last_ic     = (ic_q == in_ch_q - 7'd1);
	assign last_tap    = last_c && last_r && last_ic;
	assign base_ic_nxt = base_ic_q + 28'(hw_q);

	// Load requests write straight into the stores.
	assign img_wr_en    = in_accept && (func_t'(func) == FUNC_LOAD_SAMPLE)
		&& (int'(load_address) < IMAGE_WORDS);
	assign wgt_wr_en    = in_accept && (func_t'(func) == FUNC_LOAD_WEIGHT)
		&& (int'(load_address) < WEIGHT_WORDS);
	assign bias_wr_en   = in_accept && (func_t'(func) == FUNC_LOAD_BIAS)
		&& (int'(load_address) < MAX_OUT_CHANNELS);
	assign bias_wr_addr = BIAS_AW'(load_address);

	c2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(IMAGE_WORDS)) u_image (
		.clk     (clk),
		.wr_en   (img_wr_en),
		.wr_addr (IMAGE_AW'(load_address)),
		.wr_data (load_value[SAMPLE_W-1:0]),
		.rd_en   (tap_rd_en),
		.rd_addr (xa[IMAGE_AW-1:0]),
		.rd_data (img_rd)
	);

	c2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(WEIGHT_WORDS)) u_weight (
		.clk     (clk),
		.wr_en   (wgt_wr_en),
		.wr_addr (WEIGHT_AW'(load_address)),
		.wr_data (load_value[SAMPLE_W-1:0]),
		.rd_en   (tap_rd_en),
		.rd_addr (ka_q[WEIGHT_AW-1:0]),
		.rd_data (wgt_rd)
	);

	c2d_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_OUT_CHANNELS)) u_bias (
		.clk     (clk),
		.wr_en   (bias_wr_en),
		.wr_addr (bias_wr_addr),
		.wr_data (load_value),
		.rd_en   (in_accept),
		.rd_addr (BIAS_AW'(out_channel)),
		.rd_data (bias_rd)
	);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SETUP) begin
			unique case (step_q)
				SU_RS: begin
					mul_a = 18'(orow_q);
					mul_b = 18'(stride);
				end
				SU_CS: begin
					mul_a = 18'(ocol_q);
					mul_b = 18'(stride);
				end
				SU_IMGC: begin
					mul_a = 18'(img_q);
					mul_b = 18'(in_ch_q);
				end
				SU_HW: begin
					mul_a = 18'(in_h_q);
					mul_b = 18'(in_w_q);
				end
				SU_KK: begin
					mul_a = 18'(k_h_q);
					mul_b = 18'(k_w_q);
				end
				SU_IH0W: begin
					mul_a = 18'(ih0);
					mul_b = 18'(in_w_q);
				end
				SU_CKK: begin
					mul_a = 18'(in_ch_q);
					mul_b = 18'(kk_q);
				end
				SU_CHAN0: begin
					mul_a = 18'(imgc_q);
					mul_b = 18'(hw_q);
				end
				SU_KA0: begin
					mul_a = 18'(oc_q);
					mul_b = 18'(ckk_q);
				end
				SU_LAST: begin
					mul_a = '0;
					mul_b = '0;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else begin
			mul_a = 18'($signed(img_rd));
			mul_b = 18'($signed(wgt_rd));
		end
	end

	// Saturate the accumulator to Q16.16 and pick the status.
	always_comb begin
		acc_fits = (acc_q[ACC_W-1:VALUE_W-1] == '0) || (acc_q[ACC_W-1:VALUE_W-1] == '1);
		priority if (grid_bad_q) begin
			fin_status = STATUS_GRID;
		end else if (ovf_q) begin
			fin_status = STATUS_OVERRUN;
		end else begin
			fin_status = STATUS_OK;
		end
		priority if (fin_status != STATUS_OK) begin
			fin_value = '0;
		end else if (acc_fits) begin
			fin_value = acc_q[VALUE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			fin_value = RESULT_MIN;
		end else begin
			fin_value = RESULT_MAX;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q    <= 7'd1;
			in_h_q     <= 7'd8;
			in_w_q     <= 7'd8;
			out_ch_q   <= 7'd1;
			k_h_q      <= 4'd3;
			k_w_q      <= 4'd3;
			step_q_cfg <= 4'd1;
			pad_q      <= 3'd0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IN_CHANNELS:  in_ch_q    <= cfg_data;
				CFG_IN_HEIGHT:    in_h_q     <= cfg_data;
				CFG_IN_WIDTH:     in_w_q     <= cfg_data;
				CFG_OUT_CHANNELS: out_ch_q   <= cfg_data;
				CFG_K_HEIGHT:     k_h_q      <= cfg_data[3:0];
				CFG_K_WIDTH:      k_w_q      <= cfg_data[3:0];
				CFG_STEP:         step_q_cfg <= cfg_data[3:0];
				CFG_PAD:          pad_q      <= cfg_data[2:0];
			endcase
		end
	end

	// Sequencer, pipeline valids, output valid and bias valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= SU_RS;
			tap_s1       <= 1'b0;
			mac_s2       <= 1'b0;
			out_valid_q  <= 1'b0;
			bias_valid_q <= '0;
		end else begin
			tap_s1 <= tap_rd_en;
			mac_s2 <= tap_s1;
			if (bias_wr_en) begin
				bias_valid_q[bias_wr_addr] <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (func_t'(func) == FUNC_COMPUTE)) begin
						state_q <= ST_SETUP;
						step_q  <= SU_RS;
					end
				end
				ST_SETUP: begin
					if (step_q == SU_LAST) begin
						state_q <= ST_CHECK;
					end else begin
						step_q <= setup_step_t'(step_q + 4'd1);
					end
				end
				ST_CHECK: begin
					if (!in_grid || oc_over || no_taps) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_TAP;
					end
				end
				ST_TAP: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!tap_s1 && !mac_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath: request fields, setup products, tap walk and accumulator.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (mac_s2) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (in_accept) begin
			img_q      <= image_index;
			oc_q       <= out_channel;
			orow_q     <= out_row;
			ocol_q     <= out_col;
			grid_bad_q <= 1'b0;
			ovf_q      <= 1'b0;
		end
		unique case (state_q)
			ST_SETUP: begin
				// SU_RS loads the bias; each later step stores the product issued one step earlier.
				unique case (step_q)
					SU_RS:    acc_q   <= bias_valid_q[BIAS_AW'(oc_q)]
						? ACC_W'($signed(bias_rd)) : '0;
					SU_CS:    rs_q    <= prod_q[9:0];
					SU_IMGC:  cs_q    <= prod_q[9:0];
					SU_HW:    imgc_q  <= prod_q[12:0];
					SU_KK:    hw_q    <= prod_q[13:0];
					SU_IH0W:  kk_q    <= prod_q[7:0];
					SU_CKK:   ih0w_q  <= prod_q[17:0];
					SU_CHAN0: ckk_q   <= prod_q[14:0];
					SU_KA0:   chan0_q <= prod_q[26:0];
					SU_LAST:  ka0_q   <= prod_q[20:0];
					default: begin
					end
				endcase
			end
			ST_CHECK: begin
				grid_bad_q <= !in_grid;
				ovf_q      <= in_grid && oc_over;
				ic_q       <= '0;
				r_q        <= '0;
				c_q        <= '0;
				ih_q       <= ih0;
				iw_q       <= iw0;
				ka_q       <= ka0_q;
				base_ic_q  <= 28'(chan0_q);
				row_q      <= $signed({3'b000, chan0_q}) + 30'(ih0w_q);
			end
			ST_TAP: begin
				if (tap_over) begin
					ovf_q <= 1'b1;
				end
				ka_q <= ka_q + 21'd1;
				if (last_c) begin
					c_q  <= '0;
					iw_q <= iw0;
					if (last_r) begin
						// Next input channel plane.
						r_q       <= '0;
						ih_q      <= ih0;
						ic_q      <= ic_q + 7'd1;
						base_ic_q <= base_ic_nxt;
						row_q     <= $signed({2'b00, base_ic_nxt}) + 30'(ih0w_q);
					end else begin
						r_q   <= r_q + 4'd1;
						ih_q  <= ih_q + 12'sd1;
						row_q <= row_q + $signed(30'(in_w_q));
					end
				end else begin
					c_q  <= c_q + 4'd1;
					iw_q <= iw_q + 12'sd1;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					result_q <= fin_value;
					status_q <= fin_status;
				end
			end
			ST_IDLE, ST_DRAIN: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

	// A result appears only after the finish state has loaded it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish state");

	// A flagged result carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != STATUS_OK)) |-> (result_q == '0))
		else $error("flagged result with nonzero value");

	// The result is formed only once the multiply pipeline has emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!tap_s1 && !mac_s2))
		else $error("finish reached with products in flight");

	// Every accumulated product comes from an earlier store read, carried through tap_s1 and mac_s2.
	assert property (@(posedge clk) disable iff (!arst_n)
		mac_s2 |-> $past(tap_rd_en, 2))
		else $error("product accumulated without a tap read");

	// A bias load marks its entry as written.
	assert property (@(posedge clk) disable iff (!arst_n)
		bias_wr_en |=> bias_valid_q[$past(bias_wr_addr)])
		else $error("bias entry not marked after load");

endmodule

// File: sim/tb.sv
// Self-checking testbench for the direct NCHW 2D convolution engine.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import c2d_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 32;

	// One expected compute result.
	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   code;
	} point_result_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index    = CFG_IN_CHANNELS;
	logic [CFG_DATA_W-1:0]     cfg_data     = '0;
	logic                      in_valid     = 1'b0;
	logic                      in_stall;
	logic [FUNC_W-1:0]         func         = FUNC_LOAD_WEIGHT;
	logic [LOAD_ADDR_W-1:0]    load_address = '0;
	logic signed [VALUE_W-1:0] load_value   = '0;
	logic [IDX_W-1:0]          image_index  = '0;
	logic [IDX_W-1:0]          out_channel  = '0;
	logic [IDX_W-1:0]          out_row      = '0;
	logic [IDX_W-1:0]          out_col      = '0;
	logic                      out_valid;
	logic                      out_stall    = 1'b0;
	logic signed [VALUE_W-1:0] result_value;
	logic [STATUS_W-1:0]       status;

	// Mirror of the engine's stores, with a written flag per image and weight entry.
	logic signed [SAMPLE_W-1:0] sample_mem [IMAGE_WORDS];
	logic signed [SAMPLE_W-1:0] weight_mem [WEIGHT_WORDS];
	logic signed [VALUE_W-1:0]  bias_mem   [MAX_OUT_CHANNELS] = '{default: '0};
	bit                         sample_set [IMAGE_WORDS];
	bit                         weight_set [WEIGHT_WORDS];

	// Mirror of the geometry registers, at their reset values.
	logic [6:0] geo_ch   = 7'd1;
	logic [6:0] geo_h    = 7'd8;
	logic [6:0] geo_w    = 7'd8;
	logic [6:0] geo_oc   = 7'd1;
	logic [3:0] geo_kh   = 4'd3;
	logic [3:0] geo_kw   = 4'd3;
	logic [3:0] geo_step = 4'd1;
	logic [2:0] geo_pad  = 3'd0;

	point_result_t pending_points [$];
	int            missing_samples [$];
	int            missing_weights [$];
	int            send_idle_pct = 15;
	int            recv_idle_pct = 84;
	int            mismatches    = 0;

	conv2d_direct_mac u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The result side stalls at random, one decision per cycle.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Compare each accepted result with the oldest outstanding point.
	always @(posedge clk) begin
		point_result_t want;
		if (out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				report_mismatch("result with no request waiting", result_value, '0);
			end else begin
				want = pending_points.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (status !== want.code)
					report_mismatch("status", status, want.code);
			end
		end
	end

	// Give up when neither channel has moved for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int grid_span(int size, int kern, int stride);
		int span;
		span = size + 2 * int'(geo_pad);
		if (span < kern)
			return 0;
		return (span - kern) / stride + 1;
	endfunction

	// Convolution of one output point under the current geometry.  With gather set,
	// every in-store operand that has never been written is listed instead.
	function automatic point_result_t convolve_point(int img, int oc, int row, int col,
			bit gather);
		point_result_t res;
		int     ch, h, w, kh, kw, pad, stride, out_h, out_w, ih, iw;
		longint acc, xa, ka;
		bit     stop;
		ch     = geo_ch;
		h      = geo_h;
		w      = geo_w;
		kh     = geo_kh;
		kw     = geo_kw;
		pad    = geo_pad;
		stride = (geo_step == 0) ? 1 : int'(geo_step);
		out_h  = grid_span(h, kh, stride);
		out_w  = grid_span(w, kw, stride);
		acc    = 0;
		res.code = STATUS_OK;
		if (oc >= int'(geo_oc) || row >= out_h || col >= out_w)
			res.code = STATUS_GRID;
		else
			acc = bias_mem[oc];
		stop = (res.code != STATUS_OK);
		for (int ic = 0; ic < ch && !stop; ic++) begin
			for (int r = 0; r < kh && !stop; r++) begin
				ih = row * stride + r - pad;
				if (ih < 0 || ih >= h)
					continue;
				for (int c = 0; c < kw && !stop; c++) begin
					iw = col * stride + c - pad;
					if (iw < 0 || iw >= w)
						continue;
					xa = ((longint'(img) * ch + ic) * h + ih) * w + iw;
					ka = ((longint'(oc) * ch + ic) * kh + r) * kw + c;
					if (gather) begin
						if (xa < IMAGE_WORDS && !sample_set[xa])
							missing_samples.push_back(int'(xa));
						if (ka < WEIGHT_WORDS && !weight_set[ka])
							missing_weights.push_back(int'(ka));
					end else if (xa >= IMAGE_WORDS || ka >= WEIGHT_WORDS) begin
						res.code = STATUS_OVERRUN;
						stop = 1'b1;
					end else begin
						acc += sample_mem[xa] * weight_mem[ka];
					end
				end
			end
		end
		// Errors return zero; otherwise narrow to Q16.16 with saturation.
		if (res.code != STATUS_OK)
			acc = 0;
		else if (acc > RESULT_MAX)
			acc = RESULT_MAX;
		else if (acc < RESULT_MIN)
			acc = RESULT_MIN;
		res.value = acc[31:0];
		return res;
	endfunction

	// Random word with the Q8.8 and Q16.16 extremes turning up often.
	function automatic logic [31:0] random_word();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(9))
			0: v[15:0] = 16'h7FFF;
			1: v[15:0] = 16'h8000;
			2: v[15:0] = 16'hFFFF;
			3: v = 32'h7FFF_FFFF;
			4: v = 32'h8000_0000;
			default: ;
		endcase
		return v;
	endfunction

	// Present one request after a random gap and track its effect once accepted.
	task automatic send_request(func_t op, int addr, logic [31:0] value, int img, int oc,
			int row, int col);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= op;
		load_address <= addr;
		load_value   <= value;
		image_index  <= img;
		out_channel  <= oc;
		out_row      <= row;
		out_col      <= col;
		do @(posedge clk); while (in_stall);
		case (op)
			FUNC_LOAD_WEIGHT: begin
				weight_mem[addr] = value[15:0];
				weight_set[addr] = 1'b1;
			end
			FUNC_LOAD_BIAS: begin
				if (addr < MAX_OUT_CHANNELS)
					bias_mem[addr] = value;
			end
			FUNC_LOAD_SAMPLE: begin
				sample_mem[addr] = value[15:0];
				sample_set[addr] = 1'b1;
			end
			default: pending_points.push_back(convolve_point(img, oc, row, col, 1'b0));
		endcase
	endtask

	// Load request with the unused compute fields left random.
	task automatic load_word(func_t op, int addr, logic [31:0] value);
		send_request(op, addr, value, $urandom_range(63), $urandom_range(63),
			$urandom_range(63), $urandom_range(63));
	endtask

	// Compute request, preceded by loads of any operand it would read unwritten.
	task automatic request_point(int img, int oc, int row, int col);
		missing_samples.delete();
		missing_weights.delete();
		void'(convolve_point(img, oc, row, col, 1'b1));
		foreach (missing_samples[i])
			load_word(FUNC_LOAD_SAMPLE, missing_samples[i], random_word());
		foreach (missing_weights[i])
			load_word(FUNC_LOAD_WEIGHT, missing_weights[i], random_word());
		send_request(FUNC_COMPUTE, $urandom_range(4095), $urandom(), img, oc, row, col);
	endtask

	// Hold the sender off until every result is back and the engine has gone quiet.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_IN_CHANNELS:  geo_ch   = data;
			CFG_IN_HEIGHT:    geo_h    = data;
			CFG_IN_WIDTH:     geo_w    = data;
			CFG_OUT_CHANNELS: geo_oc   = data;
			CFG_K_HEIGHT:     geo_kh   = data[3:0];
			CFG_K_WIDTH:      geo_kw   = data[3:0];
			CFG_STEP:         geo_step = data[3:0];
			CFG_PAD:          geo_pad  = data[2:0];
		endcase
	endtask

	task automatic set_geometry(int ch, int h, int w, int oc, int kh, int kw, int step,
			int pad);
		drain_results();
		write_reg(CFG_IN_CHANNELS, ch);
		write_reg(CFG_IN_HEIGHT, h);
		write_reg(CFG_IN_WIDTH, w);
		write_reg(CFG_OUT_CHANNELS, oc);
		write_reg(CFG_K_HEIGHT, kh);
		write_reg(CFG_K_WIDTH, kw);
		write_reg(CFG_STEP, step);
		write_reg(CFG_PAD, pad);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Default geometry after reset: 8x8 plane, 3x3 filter, 6x6 output grid, zero bias.
	task automatic test_reset_state();
		request_point(0, 0, 0, 0);
		request_point(0, 0, 5, 5);
		request_point(63, 0, 5, 5);
		request_point(0, 0, 6, 0);
		request_point(0, 0, 0, 6);
		request_point(0, 1, 0, 0);
	endtask

	// Bias loads outside the store are dropped, and sample and weight loads use only the low half.
	task automatic test_load_requests();
		load_word(FUNC_LOAD_BIAS, 0, 32'h0001_8000);
		load_word(FUNC_LOAD_BIAS, MAX_OUT_CHANNELS, 32'h7FFF_0000);
		load_word(FUNC_LOAD_BIAS, 4095, 32'h8000_0000);
		request_point(0, 0, 1, 1);
		load_word(FUNC_LOAD_WEIGHT, 4, 32'hABCD_0100);
		load_word(FUNC_LOAD_SAMPLE, 18, 32'h1234_FF00);
		request_point(0, 0, 1, 1);
	endtask

	// A single tap makes the sum easy to push past either end of Q16.16.
	task automatic test_saturation();
		set_geometry(1, 1, 1, 1, 1, 1, 1, 0);
		load_word(FUNC_LOAD_SAMPLE, 0, 32'h0000_7FFF);
		load_word(FUNC_LOAD_WEIGHT, 0, 32'h0000_7FFF);
		load_word(FUNC_LOAD_BIAS, 0, 32'h7FFF_FFFF);
		request_point(0, 0, 0, 0);
		load_word(FUNC_LOAD_SAMPLE, 0, 32'h0000_8000);
		load_word(FUNC_LOAD_BIAS, 0, 32'h8000_0000);
		request_point(0, 0, 0, 0);
		load_word(FUNC_LOAD_WEIGHT, 0, 32'h0000_8000);
		request_point(0, 0, 0, 0);
	endtask

	task automatic test_geometry_extremes();
		// Widest border and filter, a stride of 8; spare high bits must be dropped.
		set_geometry(1, 8, 8, 1, 127, 127, 8, 127);
		request_point(0, 0, 0, 0);
		request_point(5, 0, 0, 0);
		request_point(0, 0, 1, 0);
		// A stride of zero behaves as a stride of one.
		set_geometry(1, 4, 4, 1, 2, 2, 0, 1);
		request_point(0, 0, 4, 4);
		request_point(0, 0, 2, 3);
		request_point(0, 0, 5, 0);
		// With no input channels the result is the bias alone.
		set_geometry(0, 8, 8, 2, 3, 3, 1, 0);
		load_word(FUNC_LOAD_BIAS, 1, random_word());
		request_point(0, 1, 2, 3);
		// A zero-sized filter has no taps either.
		set_geometry(2, 4, 4, 1, 0, 0, 2, 1);
		request_point(0, 0, 3, 3);
		// The filter does not fit even with the border, and there are no filters.
		set_geometry(1, 2, 2, 0, 5, 1, 1, 1);
		request_point(0, 0, 0, 0);
		// The largest grid the index fields reach; the next image lies past the store.
		set_geometry(1, 64, 64, 64, 1, 1, 1, 0);
		request_point(0, 63, 63, 63);
		request_point(1, 0, 0, 0);
		// Channel and height maxima: taps run off the end of the image or weight store.
		set_geometry(127, 127, 1, 127, 1, 1, 1, 0);
		request_point(0, 0, 63, 0);
		request_point(0, 63, 0, 0);
	endtask

	// Mostly small geometry, now and then a register at an edge.
	task automatic set_random_geometry();
		int ch, h, w, oc, kh, kw, step, pad;
		ch   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
		h    = $urandom_range(1, 12);
		w    = $urandom_range(1, 12);
		oc   = ($urandom_range(9) == 0) ? 127 * $urandom_range(1) : $urandom_range(1, 4);
		kh   = ($urandom_range(9) == 0) ? 15 * $urandom_range(1) : $urandom_range(1, 5);
		kw   = ($urandom_range(9) == 0) ? 15 * $urandom_range(1) : $urandom_range(1, 5);
		step = ($urandom_range(9) == 0) ? 8 : $urandom_range(3);
		pad  = ($urandom_range(9) == 0) ? 7 : $urandom_range(3);
		set_geometry(ch, h, w, oc, kh, kw, step, pad);
	endtask

	// Mostly points inside the grid, some requests with every field random.
	task automatic random_point();
		int stride, out_h, out_w, plane, img_lim, oc_lim;
		stride  = (geo_step == 0) ? 1 : int'(geo_step);
		out_h   = grid_span(geo_h, geo_kh, stride);
		out_w   = grid_span(geo_w, geo_kw, stride);
		plane   = int'(geo_ch) * int'(geo_h) * int'(geo_w);
		img_lim = (plane == 0) ? 63 : IMAGE_WORDS / plane;
		oc_lim  = int'(geo_oc);
		if (out_h == 0 || out_w == 0 || oc_lim == 0 || $urandom_range(9) == 0) begin
			request_point($urandom_range(63), $urandom_range(63), $urandom_range(63),
				$urandom_range(63));
		end else begin
			if (img_lim > 63)
				img_lim = 63;
			if (oc_lim > 64)
				oc_lim = 64;
			if (out_h > 64)
				out_h = 64;
			if (out_w > 64)
				out_w = 64;
			request_point($urandom_range(img_lim), $urandom_range(oc_lim - 1),
				$urandom_range(out_h - 1), $urandom_range(out_w - 1));
		end
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct);
		int pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int g = 0; g < 4; g++) begin
			set_random_geometry();
			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(99);
				if (pick < 55)
					random_point();
				else if (pick < 70)
					load_word(FUNC_LOAD_BIAS, ($urandom_range(3) == 0) ?
						$urandom_range(4095) : $urandom_range(MAX_OUT_CHANNELS - 1),
						random_word());
				else if (pick < 85)
					load_word(FUNC_LOAD_SAMPLE, $urandom_range(4095), random_word());
				else
					load_word(FUNC_LOAD_WEIGHT, $urandom_range(4095), random_word());
			end
		end
	endtask

	// Reset once, run the tests in turn, then wait for the last result.
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_load_requests();
		test_saturation();
		test_geometry_extremes();
		test_random_traffic(15, 84);
		test_random_traffic(84, 15);
		test_random_traffic(0, 0);
		drain_results();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
